>>> hw/rtl/lsse_pkg.sv
package lsse_pkg;

	localparam int NSENS     = 6;
	localparam int RAW_W     = 10;
	localparam int NORM_W    = 10;
	localparam int TOTAL_W   = 13;
	localparam int WSUM_W    = 25;
	localparam int POS_W     = 13;
	localparam int SPEED_W   = 9;
	localparam int DIV_NW    = 24;
	localparam int DIV_DW    = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 12;

	localparam logic [NORM_W-1:0] NORM_FULL   = 10'd1000;
	localparam logic [NSENS-1:0]  ALL_SENSORS = 6'h3F;
	localparam int                NEAR_CENTER = 100;

	localparam logic [1:0] OP_CLEAR_CAL = 2'd0;
	localparam logic [1:0] OP_CAL       = 2'd1;
	localparam logic [1:0] OP_DRIVE     = 2'd2;
	localparam logic [1:0] OP_RUN       = 2'd3;

	localparam logic [1:0] SIDE_UNKNOWN = 2'd0;
	localparam logic [1:0] SIDE_LEFT    = 2'd1;
	localparam logic [1:0] SIDE_RIGHT   = 2'd2;

	localparam logic [2:0] EDGE_L = 3'd1;
	localparam logic [2:0] EDGE_R = 3'd2;
	localparam logic [2:0] EDGE_W = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_FWD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIV   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DB    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BLACK = 3'd6;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] dividend;
		logic [DIV_DW-1:0] divisor;
	} div_req_t;

	function automatic logic signed [12:0] tap_weight(input logic [2:0] idx);
		logic signed [12:0] w;
		case (idx)
			3'd0:    w = -13'sd2500;
			3'd1:    w = -13'sd1500;
			3'd2:    w = -13'sd500;
			3'd3:    w = 13'sd500;
			3'd4:    w = 13'sd1500;
			default: w = 13'sd2500;
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/lsse_in_if.sv
interface lsse_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [9:0] raw_0;
	logic [9:0] raw_1;
	logic [9:0] raw_2;
	logic [9:0] raw_3;
	logic [9:0] raw_4;
	logic [9:0] raw_5;

	modport source (output valid, opcode, raw_0, raw_1, raw_2, raw_3, raw_4, raw_5,
		input ready);
	modport sink (input valid, opcode, raw_0, raw_1, raw_2, raw_3, raw_4, raw_5,
		output ready);
endinterface

>>> hw/rtl/lsse_out_if.sv
interface lsse_out_if;
	logic               valid;
	logic               ready;
	logic signed [8:0]  left_speed;
	logic signed [8:0]  right_speed;
	logic               on_line;
	logic signed [12:0] line_position;
	logic [5:0]         black_mask;
	logic               new_crossline;
	logic [7:0]         crossline_count;

	modport source (output valid, left_speed, right_speed, on_line, line_position,
		black_mask, new_crossline, crossline_count, input ready);
	modport sink (input valid, left_speed, right_speed, on_line, line_position,
		black_mask, new_crossline, crossline_count, output ready);
endinterface

>>> hw/rtl/lsse_cfg_if.sv
interface lsse_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [11:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/lsse_div.sv
module lsse_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lsse_pkg::div_req_t              req,
	output logic                            done,
	output logic [lsse_pkg::DIV_NW-1:0]     quot
);
	import lsse_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   rem_q;
	logic [DIV_DW:0]   rem_sh;
	logic              fits;

	// one quotient bit per cycle, restoring
	assign rem_sh = {rem_q[DIV_DW-1:0], num_q[DIV_NW-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			num_q <= {num_q[DIV_NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = num_q;

	property p_no_start_busy;
		@(posedge clk) disable iff (!arst_n) busy_q && !done_q |=> !done_q || !busy_q;
	endproperty
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |=> !busy_q || cnt_q == 5'd0) else $error("divider count not restarted");
	a_done_pulse: assert property (p_no_start_busy) else $error("divider done misplaced");
endmodule

>>> hw/rtl/line_sensor_steering_engine.sv
// Line sensor steering engine.
// in_ch carries one frame: an opcode and six raw IR readings, leftmost first.
// out_ch returns exactly one word per frame: motor speeds, line position,
// black mask and crossline status. cfg_ch writes the seven control registers
// (index 0..6); it is always ready and is meant to be used while idle.
// A drive frame normalizes the six sensors one after another through a shared
// bit-serial divider, then, when a line is found, divides the weighted sum by
// the total on the same divider. A sensor with a bad calibration skips its
// division. Calibration, clear and run-control frames go straight to the
// finishing step; their word is loaded into the output register when it frees.
// The input is ready again as soon as a result is loaded into the output
// register, so the next frame is taken while that word waits. When the
// receiver stalls, the finished frame holds in its last step until the
// output register frees. Reset restores register defaults, clears the
// calibration to empty (min at ADC maximum, max at zero) and the run state.
module line_sensor_steering_engine #(
	parameter int CROSS_WINDOW = 30,
	parameter int ADC_BITS     = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	lsse_in_if.sink     in_ch,
	lsse_out_if.source  out_ch,
	lsse_cfg_if.sink    cfg_ch
);
	import lsse_pkg::*;

	localparam int AW = ADC_BITS;
	localparam logic [AW-1:0] ADC_MAX = {AW{1'b1}};

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PREP  = 6'b000010,
		S_NWAIT = 6'b000100,
		S_CENT  = 6'b001000,
		S_CWAIT = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q;

	// control registers
	logic [7:0]  fwd_q, piv_q;
	logic [11:0] db_q;
	logic [9:0]  thr_q, noise_q, range_q;
	logic        black_q;

	logic [AW-1:0] cal_min_q [NSENS];
	logic [AW-1:0] cal_max_q [NSENS];
	logic [AW-1:0] raw_q [NSENS];
	logic [1:0]    op_q;
	logic [2:0]    idx_q;

	logic [NSENS-1:0]          mask_q;
	logic [NORM_W-1:0]         peak_q;
	logic [TOTAL_W-1:0]        total_q;
	logic signed [WSUM_W-1:0]  wsum_q;
	logic signed [POS_W-1:0]   pos_q;

	logic [1:0]       last_side_q;
	logic [NSENS-1:0] seen_q;
	logic             checking_q;
	logic [4:0]       timer_q;
	logic [2:0]       edges_q;
	logic             latched_q;
	logic [7:0]       cross_total_q;

	logic out_valid_q;

	div_req_t          div_req;
	logic              div_done;
	logic [DIV_NW-1:0] div_quot;

	lsse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	// clamp incoming readings to the ADC range
	function automatic logic [AW-1:0] clamp_raw(input logic [RAW_W-1:0] r);
		logic [15:0] re;
		re = 16'(r);
		return (re > 16'(ADC_MAX)) ? ADC_MAX : AW'(re);
	endfunction

	// normalization setup for the current sensor
	logic [AW-1:0]    lo, hi, rv, rc, span, diff;
	logic             bad;
	logic [AW+9:0]    prod;
	always_comb begin
		lo   = cal_min_q[idx_q];
		hi   = cal_max_q[idx_q];
		rv   = raw_q[idx_q];
		span = hi - lo;
		bad  = (hi <= lo) || (16'(span) < 16'(range_q));
		rc   = (rv < lo) ? lo : ((rv > hi) ? hi : rv);
		diff = black_q ? hi - rc : rc - lo;
		prod = (AW + 10)'(diff) * (AW + 10)'(NORM_FULL);
	end

	logic [NORM_W-1:0] norm_v;
	logic              acc_en;
	always_comb begin
		logic [DIV_NW-1:0] v;
		v = div_quot;
		if (v > DIV_NW'(NORM_FULL))
			v = DIV_NW'(NORM_FULL);
		if (v < DIV_NW'(noise_q))
			v = '0;
		norm_v = (state_q == S_NWAIT) ? NORM_W'(v) : '0;
		acc_en = (state_q == S_PREP && bad) || (state_q == S_NWAIT && div_done);
	end

	logic              found;
	logic [DIV_NW-1:0] wabs;
	assign found = (peak_q >= thr_q) && (total_q != '0);
	assign wabs  = wsum_q[WSUM_W-1] ? DIV_NW'(-wsum_q) : DIV_NW'(wsum_q);

	always_comb begin
		div_req = '0;
		if (state_q == S_PREP) begin
			div_req.start    = !bad;
			div_req.dividend = DIV_NW'(prod);
			div_req.divisor  = DIV_DW'(span);
		end else if (state_q == S_CENT) begin
			div_req.start    = found;
			div_req.dividend = wabs;
			div_req.divisor  = DIV_DW'(total_q);
		end
	end

	// steering
	logic signed [SPEED_W-1:0] ls_v, rs_v;
	logic [1:0]                side_n;
	always_comb begin
		logic signed [13:0] p, d;
		logic signed [SPEED_W-1:0] f, v;
		p = 14'(pos_q);
		d = $signed({2'b00, db_q});
		f = $signed({1'b0, fwd_q});
		v = $signed({1'b0, piv_q});
		side_n = last_side_q;
		ls_v = '0;
		rs_v = '0;
		if (found) begin
			if (p < -d) begin
				side_n = SIDE_LEFT; ls_v = -v; rs_v = v;
			end else if (p > d) begin
				side_n = SIDE_RIGHT; ls_v = v; rs_v = -v;
			end else begin
				if (p < -14'sd100)
					side_n = SIDE_LEFT;
				else if (p > 14'sd100)
					side_n = SIDE_RIGHT;
				ls_v = f; rs_v = f;
			end
		end else if (last_side_q == SIDE_LEFT) begin
			ls_v = -v; rs_v = v;
		end else if (last_side_q == SIDE_RIGHT) begin
			ls_v = v; rs_v = -v;
		end
	end

	// crossline detector
	logic [NSENS-1:0] seen_n;
	logic             checking_n, latched_n, fresh;
	logic [4:0]       timer_n;
	logic [2:0]       edges_n;
	logic [7:0]       cross_n;
	always_comb begin
		logic [2:0] cnt;
		logic       go;
		cnt = '0;
		for (int i = 0; i < NSENS; i++)
			cnt = cnt + 3'(mask_q[i]);
		seen_n     = seen_q;
		checking_n = checking_q;
		timer_n    = timer_q;
		edges_n    = edges_q;
		latched_n  = latched_q;
		cross_n    = cross_total_q;
		fresh      = 1'b0;
		go         = checking_q;
		if (latched_q) begin
			if (cnt <= 3'd2)
				latched_n = 1'b0;
		end else begin
			if (!checking_q && cnt >= 3'd4) begin
				seen_n = '0; timer_n = '0; edges_n = '0;
				checking_n = 1'b1;
				go = 1'b1;
			end
			if (go) begin
				seen_n = seen_n | mask_q;
				if (mask_q[0])
					edges_n = edges_n | EDGE_L;
				if (mask_q[NSENS-1])
					edges_n = edges_n | EDGE_R;
				if (cnt >= 3'd5)
					edges_n = edges_n | EDGE_W;
				timer_n = timer_n + 5'd1;
				if (seen_n == ALL_SENSORS && edges_n == (EDGE_L | EDGE_R | EDGE_W)) begin
					if (cross_n != 8'd255)
						cross_n = cross_n + 8'd1;
					latched_n = 1'b1;
					fresh = 1'b1;
					seen_n = '0; timer_n = '0; edges_n = '0; checking_n = 1'b0;
				end else if (timer_n >= 5'(CROSS_WINDOW)) begin
					seen_n = '0; timer_n = '0; edges_n = '0; checking_n = 1'b0;
				end
			end
		end
	end

	logic out_free;
	assign out_free     = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = (state_q == S_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			idx_q         <= '0;
			fwd_q         <= 8'd150;
			piv_q         <= 8'd140;
			db_q          <= 12'd700;
			thr_q         <= 10'd300;
			noise_q       <= 10'd40;
			range_q       <= 10'd40;
			black_q       <= 1'b1;
			last_side_q   <= SIDE_UNKNOWN;
			seen_q        <= '0;
			checking_q    <= 1'b0;
			timer_q       <= '0;
			edges_q       <= '0;
			latched_q     <= 1'b0;
			cross_total_q <= '0;
			for (int i = 0; i < NSENS; i++) begin
				cal_min_q[i] <= ADC_MAX;
				cal_max_q[i] <= '0;
			end
		end else begin
			// load a finished word, or drop the one just taken
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			if (cfg_ch.valid) begin
				unique case (cfg_ch.index)
					REG_FWD:   fwd_q   <= cfg_ch.data[7:0];
					REG_PIV:   piv_q   <= cfg_ch.data[7:0];
					REG_DB:    db_q    <= cfg_ch.data;
					REG_THR:   thr_q   <= cfg_ch.data[9:0];
					REG_NOISE: noise_q <= cfg_ch.data[9:0];
					REG_RANGE: range_q <= cfg_ch.data[9:0];
					REG_BLACK: black_q <= cfg_ch.data[0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (in_ch.valid)
						state_q <= (in_ch.opcode == OP_DRIVE) ? S_PREP : S_FIN;
				end
				S_PREP: begin
					if (bad) begin
						if (idx_q == 3'(NSENS - 1))
							state_q <= S_CENT;
						else
							idx_q <= idx_q + 3'd1;
					end else begin
						state_q <= S_NWAIT;
					end
				end
				S_NWAIT: begin
					if (div_done) begin
						if (idx_q == 3'(NSENS - 1)) begin
							state_q <= S_CENT;
						end else begin
							idx_q   <= idx_q + 3'd1;
							state_q <= S_PREP;
						end
					end
				end
				S_CENT:  state_q <= found ? S_CWAIT : S_FIN;
				S_CWAIT: if (div_done) state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
						case (op_q)
							OP_CLEAR_CAL: begin
								for (int i = 0; i < NSENS; i++) begin
									cal_min_q[i] <= ADC_MAX;
									cal_max_q[i] <= '0;
								end
							end
							OP_CAL: begin
								for (int i = 0; i < NSENS; i++) begin
									if (raw_q[i] < cal_min_q[i])
										cal_min_q[i] <= raw_q[i];
									if (raw_q[i] > cal_max_q[i])
										cal_max_q[i] <= raw_q[i];
								end
							end
							OP_RUN: begin
								last_side_q   <= SIDE_UNKNOWN;
								cross_total_q <= '0;
								latched_q     <= 1'b0;
								seen_q        <= '0;
								checking_q    <= 1'b0;
								timer_q       <= '0;
								edges_q       <= '0;
							end
							default: begin
								last_side_q   <= side_n;
								seen_q        <= seen_n;
								checking_q    <= checking_n;
								timer_q       <= timer_n;
								edges_q       <= edges_n;
								latched_q     <= latched_n;
								cross_total_q <= cross_n;
							end
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			op_q     <= in_ch.opcode;
			raw_q[0] <= clamp_raw(in_ch.raw_0);
			raw_q[1] <= clamp_raw(in_ch.raw_1);
			raw_q[2] <= clamp_raw(in_ch.raw_2);
			raw_q[3] <= clamp_raw(in_ch.raw_3);
			raw_q[4] <= clamp_raw(in_ch.raw_4);
			raw_q[5] <= clamp_raw(in_ch.raw_5);
			mask_q   <= '0;
			peak_q   <= '0;
			total_q  <= '0;
			wsum_q   <= '0;
			pos_q    <= '0;
		end
		if (acc_en) begin
			if (norm_v >= thr_q)
				mask_q[idx_q] <= 1'b1;
			if (norm_v > peak_q)
				peak_q <= norm_v;
			total_q <= total_q + TOTAL_W'(norm_v);
			wsum_q  <= wsum_q + WSUM_W'($signed({1'b0, norm_v}) * tap_weight(idx_q));
		end
		if (state_q == S_CWAIT && div_done)
			pos_q <= wsum_q[WSUM_W-1] ? -POS_W'(div_quot) : POS_W'(div_quot);
		if (state_q == S_FIN && out_free) begin
			if (op_q == OP_DRIVE) begin
				out_ch.left_speed    <= ls_v;
				out_ch.right_speed   <= rs_v;
				out_ch.on_line       <= found;
				out_ch.line_position <= found ? pos_q : '0;
				out_ch.black_mask    <= mask_q;
				out_ch.new_crossline <= fresh;
				out_ch.crossline_count <= cross_n;
			end else begin
				out_ch.left_speed    <= '0;
				out_ch.right_speed   <= '0;
				out_ch.on_line       <= 1'b0;
				out_ch.line_position <= '0;
				out_ch.black_mask    <= '0;
				out_ch.new_crossline <= 1'b0;
				out_ch.crossline_count <= (op_q == OP_RUN) ? 8'd0 : cross_total_q;
			end
		end
	end

	a_fresh_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ch.new_crossline |-> out_ch.crossline_count != 8'd0)
		else $error("crossline confirmed with zero count");
	a_lost_center: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.on_line |-> out_ch.line_position == '0)
		else $error("position set without a line");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> state_q != S_IDLE)
		else $error("frame accepted but engine idle");
endmodule
